// ===== hdl/dbd_pkg.sv =====
// Shared types and constants for the depth box deprojection block.
// Used by every module under hdl; no dependencies.
package dbd_pkg;

	// defaults for the top-level parameters
	localparam int IMAGE_WIDTH_DEF  = 640;
	localparam int IMAGE_HEIGHT_DEF = 480;
	localparam int DEPTH_BITS_DEF   = 16;

	// width of the focal and centre registers (Q10.6)
	localparam int CAM_W = 16;

	// configuration register indexes
	localparam logic [2:0] REG_FOCAL_X        = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y        = 3'd1;
	localparam logic [2:0] REG_CENTER_X       = 3'd2;
	localparam logic [2:0] REG_CENTER_Y       = 3'd3;
	localparam logic [2:0] REG_LATERAL_OFFSET = 3'd4;

	// reset values
	localparam logic [15:0] FOCAL_X_RST  = 16'd39424;
	localparam logic [15:0] FOCAL_Y_RST  = 16'd39424;
	localparam logic [15:0] CENTER_X_RST = 16'd20214;
	localparam logic [15:0] CENTER_Y_RST = 16'd15252;
	localparam logic [7:0]  OFFSET_RST   = 8'd35;

	// input item kinds (s_tuser)
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_BOX   = 1'b1;

	// saturation bound of pos_x and pos_y
	localparam int POS_LIMIT = 42000000;
	localparam int POS_W     = 27;

	// sideband carried alongside the divider lanes
	typedef struct packed {
		logic        valid;
		logic [7:0]  object_class;
		logic        end_of_message;
		logic        neg_x;
		logic        neg_y;
		logic [15:0] pos_z;
	} side_t;

endpackage

// ===== hdl/dbd_depth_mem.sv =====
// Depth pixel store: one write port, one registered read port.
// Depends on dbd_pkg.
module dbd_depth_mem import dbd_pkg::*; #(
	parameter int ENTRIES    = IMAGE_WIDTH_DEF * IMAGE_HEIGHT_DEF,
	parameter int ADDR_W     = $clog2(IMAGE_WIDTH_DEF * IMAGE_HEIGHT_DEF),
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  logic [DEPTH_BITS-1:0] wdata,
	input  logic                  re,
	input  logic [ADDR_W-1:0]     raddr,
	output logic [DEPTH_BITS-1:0] rdata
);

	logic [DEPTH_BITS-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/dbd_project.sv =====
// Pipelined restoring divider, two lanes (x and y), two quotient bits per stage.
// Carries the item sideband alongside. Depends on dbd_pkg.
module dbd_project import dbd_pkg::*; #(
	parameter int NUM_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [CAM_W-1:0] focal_x,
	input  logic [CAM_W-1:0] focal_y,
	input  side_t            in_side,
	input  logic [NUM_W-1:0] in_mag_x,
	input  logic [NUM_W-1:0] in_mag_y,
	output side_t            out_side,
	output logic [NUM_W-1:0] out_quo_x,
	output logic [NUM_W-1:0] out_quo_y
);

	localparam int STAGES = NUM_W / 2;
	localparam int ST_W   = CAM_W + NUM_W;

	// one restoring step: {rem, w} where w holds numerator bits above, quotient below
	function automatic logic [ST_W-1:0] div_step(input logic [ST_W-1:0] st,
			input logic [CAM_W-1:0] dv);
		logic [CAM_W:0]   t;
		logic             ge;
		logic [CAM_W-1:0] rem;
		logic [NUM_W-1:0] w;
		t   = {st[ST_W-1:NUM_W], st[NUM_W-1]};
		ge  = (t >= {1'b0, dv});
		rem = ge ? CAM_W'(t - {1'b0, dv}) : t[CAM_W-1:0];
		w   = {st[NUM_W-2:0], ge};
		return {rem, w};
	endfunction

	logic [CAM_W-1:0] div_x;
	logic [CAM_W-1:0] div_y;

	logic [ST_W-1:0] x_in [STAGES];
	logic [ST_W-1:0] y_in [STAGES];
	side_t           sd_in [STAGES];
	logic [ST_W-1:0] x_q [STAGES];
	logic [ST_W-1:0] y_q [STAGES];
	side_t           sd_q [STAGES];

	assign div_x = (focal_x == '0) ? CAM_W'(1) : focal_x;
	assign div_y = (focal_y == '0) ? CAM_W'(1) : focal_y;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		if (i == 0) begin : g_first
			assign x_in[i]  = {{CAM_W{1'b0}}, in_mag_x};
			assign y_in[i]  = {{CAM_W{1'b0}}, in_mag_y};
			assign sd_in[i] = in_side;
		end else begin : g_next
			assign x_in[i]  = x_q[i-1];
			assign y_in[i]  = y_q[i-1];
			assign sd_in[i] = sd_q[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_q[i] <= '0;
			end else if (en) begin
				sd_q[i] <= sd_in[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[i] <= div_step(div_step(x_in[i], div_x), div_x);
				y_q[i] <= div_step(div_step(y_in[i], div_y), div_y);
			end
		end
	end

	assign out_side  = sd_q[STAGES-1];
	assign out_quo_x = x_q[STAGES-1][NUM_W-1:0];
	assign out_quo_y = y_q[STAGES-1][NUM_W-1:0];

endmodule

// ===== hdl/depth_box_deprojection.sv =====
// Depth box deprojection: depth pixel store, back-projection and result stage.
// Depends on dbd_pkg, dbd_depth_mem and dbd_project.
//
// Input items arrive on s_* (s_tuser = kind, s_tlast = last box of a message).
// A write item stores one depth pixel and gives no result; a box item reads
// the depth at the floor midpoint of its corners and gives one result item
// on m_* with x, y, z and the class, m_tlast marking the end of the message.
// An item is taken every cycle while s_tready is high, writes and boxes
// mixed in any order; a box sees every write accepted before it.
// For a box item the pixel store is read at the accepting edge, then the
// products are registered, the divider pipeline gives two quotient bits per
// stage, and the result is registered in the output register.
// Reset clears the pipeline valids and loads the camera registers with their
// defaults; the pixel store is not cleared and a pixel must be written before
// a box reads it. When the receiver stalls the result is held in the output
// register, one more goes to a skid register, and then s_tready drops and the
// whole pipeline holds until the receiver takes an item.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
module depth_box_deprojection import dbd_pkg::*; #(
	parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
	parameter int DEPTH_BITS   = DEPTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// pixel_col[9:0], pixel_row[18:10], depth_value[34:19], box_left[44:35],
	// box_right[54:45], box_top[63:55], box_bottom[72:64], class_id[80:73]
	input  logic [87:0] s_tdata,
	// action[0]
	input  logic        s_tuser,
	input  logic        s_tlast,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// object_class[7:0], pos_x[34:8], pos_y[61:35], pos_z[77:62]
	output logic [79:0] m_tdata,
	output logic        m_tlast
);

	localparam int ENTRIES = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int PROD_W  = DEPTH_BITS + CAM_W;
	localparam int NUM_W   = PROD_W + (PROD_W % 2);
	localparam int SW      = (NUM_W + 2 > 28) ? NUM_W + 2 : 28;

	// configuration registers
	logic [15:0] focal_x_q;
	logic [15:0] focal_y_q;
	logic [15:0] center_x_q;
	logic [15:0] center_y_q;
	logic [7:0]  offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			offset_q   <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:        focal_x_q  <= cfg_data;
				REG_FOCAL_Y:        focal_y_q  <= cfg_data;
				REG_CENTER_X:       center_x_q <= cfg_data;
				REG_CENTER_Y:       center_y_q <= cfg_data;
				REG_LATERAL_OFFSET: offset_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input unpack
	logic [9:0]  pixel_col;
	logic [8:0]  pixel_row;
	logic [15:0] depth_value;
	logic [9:0]  box_left;
	logic [9:0]  box_right;
	logic [8:0]  box_top;
	logic [8:0]  box_bottom;
	logic [7:0]  class_id;

	assign pixel_col   = s_tdata[9:0];
	assign pixel_row   = s_tdata[18:10];
	assign depth_value = s_tdata[34:19];
	assign box_left    = s_tdata[44:35];
	assign box_right   = s_tdata[54:45];
	assign box_top     = s_tdata[63:55];
	assign box_bottom  = s_tdata[72:64];
	assign class_id    = s_tdata[80:73];

	logic adv;
	logic accept;
	logic [10:0] sum_x;
	logic [9:0]  sum_y;
	logic [9:0]  xc;
	logic [8:0]  yc;
	logic wr_in_range;
	logic box_in_range;
	logic mem_we;
	logic mem_re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [DEPTH_BITS-1:0] rdata;

	assign s_tready = adv;
	assign accept   = s_tvalid & adv;

	assign sum_x = {1'b0, box_left} + {1'b0, box_right};
	assign sum_y = {1'b0, box_top} + {1'b0, box_bottom};
	assign xc    = sum_x[10:1];
	assign yc    = sum_y[9:1];

	assign wr_in_range  = (int'(pixel_col) < IMAGE_WIDTH) && (int'(pixel_row) < IMAGE_HEIGHT);
	assign box_in_range = (int'(xc) < IMAGE_WIDTH) && (int'(yc) < IMAGE_HEIGHT);

	assign waddr = ADDR_W'(int'(pixel_row) * IMAGE_WIDTH + int'(pixel_col));
	assign raddr = ADDR_W'(int'(yc) * IMAGE_WIDTH + int'(xc));

	// at most one item per cycle, so a read and a write never share a cycle;
	// a write is in the array before any later box reads it
	assign mem_we = accept && (s_tuser == ACT_WRITE) && wr_in_range;
	assign mem_re = accept && (s_tuser == ACT_BOX) && box_in_range;

	dbd_depth_mem #(
		.ENTRIES    (ENTRIES),
		.ADDR_W     (ADDR_W),
		.DEPTH_BITS (DEPTH_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (depth_value[DEPTH_BITS-1:0]),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// stage 1: read in flight
	logic       valid_s1;
	logic [9:0] xc_s1;
	logic [8:0] yc_s1;
	logic       inr_s1;
	logic [7:0] class_s1;
	logic       last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && (s_tuser == ACT_BOX);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xc_s1    <= xc;
			yc_s1    <= yc;
			inr_s1   <= box_in_range;
			class_s1 <= class_id;
			last_s1  <= s_tlast;
		end
	end

	// stage 1 logic: depth, offset from centre, products
	logic [DEPTH_BITS-1:0] d_s1;
	logic [15:0] xc64;
	logic [15:0] yc64;
	logic        neg_x;
	logic        neg_y;
	logic [15:0] mag_x;
	logic [15:0] mag_y;
	logic [PROD_W-1:0] prod_x;
	logic [PROD_W-1:0] prod_y;

	assign d_s1  = inr_s1 ? rdata : '0;
	assign xc64  = {xc_s1, 6'b0};
	assign yc64  = {1'b0, yc_s1, 6'b0};
	assign neg_x = xc64 < center_x_q;
	assign neg_y = yc64 < center_y_q;
	assign mag_x = neg_x ? center_x_q - xc64 : xc64 - center_x_q;
	assign mag_y = neg_y ? center_y_q - yc64 : yc64 - center_y_q;
	assign prod_x = PROD_W'(d_s1) * PROD_W'(mag_x);
	assign prod_y = PROD_W'(d_s1) * PROD_W'(mag_y);

	// stage 2: products registered
	side_t            side_s2;
	logic [NUM_W-1:0] num_x_s2;
	logic [NUM_W-1:0] num_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (adv) begin
			side_s2.valid          <= valid_s1;
			side_s2.object_class   <= class_s1;
			side_s2.end_of_message <= last_s1;
			side_s2.neg_x          <= neg_x;
			side_s2.neg_y          <= neg_y;
			side_s2.pos_z          <= 16'(d_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s2 <= NUM_W'(prod_x);
			num_y_s2 <= NUM_W'(prod_y);
		end
	end

	side_t            side_dv;
	logic [NUM_W-1:0] quo_x;
	logic [NUM_W-1:0] quo_y;

	dbd_project #(
		.NUM_W (NUM_W)
	) u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.focal_x   (focal_x_q),
		.focal_y   (focal_y_q),
		.in_side   (side_s2),
		.in_mag_x  (num_x_s2),
		.in_mag_y  (num_y_s2),
		.out_side  (side_dv),
		.out_quo_x (quo_x),
		.out_quo_y (quo_y)
	);

	// sign, offset, saturation
	logic signed [SW-1:0] qx;
	logic signed [SW-1:0] qy;
	logic signed [SW-1:0] vx;
	logic signed [SW-1:0] vy;
	logic signed [SW-1:0] lim_hi;
	logic signed [SW-1:0] lim_lo;
	logic [SW-1:0] sat_x;
	logic [SW-1:0] sat_y;
	logic [79:0] res_data;

	assign qx = signed'(SW'(quo_x));
	assign qy = signed'(SW'(quo_y));
	assign lim_hi = signed'(SW'(POS_LIMIT));
	assign lim_lo = -lim_hi;
	assign vx = (side_dv.neg_x ? -qx : qx) - signed'(SW'(offset_q));
	assign vy = side_dv.neg_y ? -qy : qy;
	assign sat_x = (vx > lim_hi) ? lim_hi : (vx < lim_lo) ? lim_lo : vx;
	assign sat_y = (vy > lim_hi) ? lim_hi : (vy < lim_lo) ? lim_lo : vy;

	assign res_data = {2'b0, side_dv.pos_z, sat_y[POS_W-1:0], sat_x[POS_W-1:0],
		side_dv.object_class};

	// output register and skid
	logic        out_valid_q;
	logic [79:0] out_data_q;
	logic        out_last_q;
	logic        skid_valid_q;
	logic [79:0] skid_data_q;
	logic        skid_last_q;
	logic        push;
	logic        pop;

	assign adv  = !skid_valid_q;
	assign push = side_dv.valid && adv;
	assign pop  = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_data_q <= skid_valid_q ? skid_data_q : res_data;
			out_last_q <= skid_valid_q ? skid_last_q : side_dv.end_of_message;
		end else if (push) begin
			skid_data_q <= res_data;
			skid_last_q <= side_dv.end_of_message;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while the output register is empty");

	a_mem_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("pixel store read and written in the same cycle");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> ($stable(valid_s1) && $stable(side_s2.valid)))
		else $error("pipeline moved while stalled");

	a_no_push_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(side_dv.valid && !adv) |=> side_dv.valid)
		else $error("result left the divider while stalled");

endmodule
